### src/mssl_pkg.sv
// Shared types and constants for the limited maximum subarray sum block.
// Used by mssl_cell and max_subarray_sum_at_most_limit; depends on nothing.
package mssl_pkg;

   localparam int ELEMENT_W  = 32;
   localparam int LIMIT_W    = 32;
   localparam int BEST_W     = 42;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   // Control flags of one search token travelling along the chain.
   typedef struct packed {
      logic live;
      logic search;
      logic last;
      logic overflow;
      logic hit;
      logic placed;
   } token_ctl_type;

endpackage

### src/mssl_cell.sv
// One store cell of the prefix chain: holds one prefix sum and refines the passing token.
// Depends on mssl_pkg for the token control type.
module mssl_cell #(
   parameter int SUM_W = 44,
   parameter bit SEED  = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  mssl_pkg::token_ctl_type  in_ctl,
   input  logic signed [SUM_W-1:0]  in_prefix,
   input  logic signed [SUM_W-1:0]  in_target,
   input  logic signed [SUM_W-1:0]  in_least,
   output mssl_pkg::token_ctl_type  out_ctl,
   output logic signed [SUM_W-1:0]  out_prefix,
   output logic signed [SUM_W-1:0]  out_target,
   output logic signed [SUM_W-1:0]  out_least
);
   import mssl_pkg::*;

   logic                    valid_ff, valid_in;
   logic signed [SUM_W-1:0] value_ff, value_in;
   token_ctl_type           ctl_ff, ctl_in;
   logic signed [SUM_W-1:0] prefix_ff, target_ff, least_ff, least_in;
   logic                    hit, take, write;

   always_comb begin
      hit   = valid_ff && in_ctl.live && in_ctl.search && (value_ff >= in_target);
      take  = hit && (!in_ctl.hit || (value_ff < in_least));
      write = in_ctl.live && in_ctl.search && !in_ctl.last && !in_ctl.placed && !valid_ff;

      ctl_in        = in_ctl;
      ctl_in.hit    = in_ctl.hit | take;
      ctl_in.placed = in_ctl.placed | write;
      least_in      = take ? value_ff : in_least;

      valid_in = valid_ff;
      value_in = value_ff;
      if (write) begin
         valid_in = 1'b1;
         value_in = in_prefix;
      end
      // The final item of an array empties the cell behind itself; a SEED cell stays valid.
      if (in_ctl.live && in_ctl.last) begin
         valid_in = SEED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= SEED;
         value_ff <= '0;
         ctl_ff   <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
         value_ff <= value_in;
         ctl_ff   <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prefix_ff <= in_prefix;
         target_ff <= in_target;
         least_ff  <= least_in;
      end
   end

   assign out_ctl    = ctl_ff;
   assign out_prefix = prefix_ff;
   assign out_target = target_ff;
   assign out_least  = least_ff;

endmodule

### src/max_subarray_sum_at_most_limit.sv
// Largest subarray sum not above a limit, over a stream of signed elements.
// Path: a final element passes the front-end registers, the STORE_ENTRIES cells and the tail before its result shows.
// Throughput: one element per cycle; a result waiting on rsp_tready stalls the whole chain.
// Reset: synchronous; clears the store, sums and flags, and sets the limit to zero.
// Depends on mssl_pkg and mssl_cell.
module max_subarray_sum_at_most_limit #(
   parameter int STORE_ENTRIES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mssl_pkg::LIMIT_W-1:0]         csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mssl_pkg::ELEMENT_W-1:0]       req_tdata,  // [31:0] element
   input  logic                                 req_tlast,  // is_last
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mssl_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [41:0] best_sum, rest zero
   output logic [mssl_pkg::RSP_USER_W-1:0]      rsp_tuser   // [0] found, [1] overflowed
);
   import mssl_pkg::*;

   localparam int RAW_W = 34 + $clog2(STORE_ENTRIES);
   localparam int SUM_W = (RAW_W > BEST_W) ? RAW_W : BEST_W;
   localparam int CNT_W = $clog2(STORE_ENTRIES + 1);

   logic                    advance;
   logic                    accept;
   logic signed [LIMIT_W-1:0] limit_ff;

   logic [CNT_W-1:0]        count_ff;
   logic signed [SUM_W-1:0] prefix_ff, prefix_sum;
   logic                    cap_ff;
   logic                    full;

   token_ctl_type           a_ctl_ff, a_ctl_in, b_ctl_ff;
   logic signed [SUM_W-1:0] a_prefix_ff, b_prefix_ff, b_target_ff;

   token_ctl_type           chain_ctl    [0:STORE_ENTRIES];
   logic signed [SUM_W-1:0] chain_prefix [0:STORE_ENTRIES];
   logic signed [SUM_W-1:0] chain_target [0:STORE_ENTRIES];
   logic signed [SUM_W-1:0] chain_least  [0:STORE_ENTRIES];

   token_ctl_type           x_ctl_ff;
   logic signed [SUM_W-1:0] cand_ff;
   logic signed [SUM_W-1:0] best_ff, best_in;
   logic                    found_ff, found_in;

   logic                    rsp_valid_ff;
   logic [BEST_W-1:0]       rsp_best_ff;
   logic                    rsp_found_ff, rsp_ovf_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid) begin
         limit_ff <= csr_wdata;
      end
   end

   // Front end: running prefix and fill count.
   assign full       = (count_ff == CNT_W'(STORE_ENTRIES));
   assign prefix_sum = prefix_ff + {{(SUM_W-ELEMENT_W){req_tdata[ELEMENT_W-1]}}, req_tdata};

   always_comb begin
      a_ctl_in          = '0;
      a_ctl_in.live     = accept;
      a_ctl_in.search   = !full;
      a_ctl_in.last     = req_tlast;
      a_ctl_in.overflow = cap_ff | full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CNT_W'(1);
         prefix_ff <= '0;
         cap_ff    <= 1'b0;
         a_ctl_ff  <= '0;
         b_ctl_ff  <= '0;
      end else if (advance) begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= a_ctl_ff;
         if (accept) begin
            if (req_tlast) begin
               count_ff  <= CNT_W'(1);
               prefix_ff <= '0;
               cap_ff    <= 1'b0;
            end else if (!full) begin
               count_ff  <= count_ff + CNT_W'(1);
               prefix_ff <= prefix_sum;
            end else begin
               cap_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_prefix_ff <= prefix_sum;
         b_prefix_ff <= a_prefix_ff;
         b_target_ff <= a_prefix_ff - {{(SUM_W-LIMIT_W){limit_ff[LIMIT_W-1]}}, limit_ff};
      end
   end

   assign chain_ctl[0]    = b_ctl_ff;
   assign chain_prefix[0] = b_prefix_ff;
   assign chain_target[0] = b_target_ff;
   assign chain_least[0]  = '0;

   for (genvar i = 0; i < STORE_ENTRIES; i++) begin : g_cell
      mssl_cell #(
         .SUM_W (SUM_W),
         .SEED  (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .in_ctl     (chain_ctl[i]),
         .in_prefix  (chain_prefix[i]),
         .in_target  (chain_target[i]),
         .in_least   (chain_least[i]),
         .out_ctl    (chain_ctl[i+1]),
         .out_prefix (chain_prefix[i+1]),
         .out_target (chain_target[i+1]),
         .out_least  (chain_least[i+1])
      );
   end

   // Tail: candidate sum, then the running best of the array.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ctl_ff <= '0;
      end else if (advance) begin
         x_ctl_ff <= chain_ctl[STORE_ENTRIES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cand_ff <= chain_prefix[STORE_ENTRIES] - chain_least[STORE_ENTRIES];
      end
   end

   always_comb begin
      best_in  = best_ff;
      found_in = found_ff;
      if (x_ctl_ff.live && x_ctl_ff.hit) begin
         if (!found_ff || (cand_ff > best_ff)) begin
            best_in = cand_ff;
         end
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= x_ctl_ff.live && x_ctl_ff.last;
         if (x_ctl_ff.live && x_ctl_ff.last) begin
            best_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            best_ff  <= best_in;
            found_ff <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && x_ctl_ff.live && x_ctl_ff.last) begin
         rsp_best_ff  <= found_in ? best_in[BEST_W-1:0] : '0;
         rsp_found_ff <= found_in;
         rsp_ovf_ff   <= x_ctl_ff.overflow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-BEST_W){1'b0}}, rsp_best_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_found_ff};

endmodule
